// ----- rtl/mhse_pkg.sv -----
package mhse_pkg;

  // Request codes carried on the input tuser field.
  localparam logic [1:0] OP_QUERY  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_PROBE_COUNT = 3'd0;
  localparam logic [2:0] REG_SEED_0      = 3'd1;
  localparam logic [2:0] REG_SEED_1      = 3'd2;
  localparam logic [2:0] REG_SEED_2      = 3'd3;
  localparam logic [2:0] REG_SEED_3      = 3'd4;

  localparam int SEED_REGS = 4;
  localparam int KEY_W     = 64;
  localparam int TOMB_W    = 14;
  localparam logic [TOMB_W-1:0] TOMB_MAX = 14'd16383;

  // Slot word flags, stored above the key.
  localparam logic [1:0] FLAG_EMPTY = 2'b00;
  localparam logic [1:0] FLAG_OCC   = 2'b01;
  localparam logic [1:0] FLAG_TOMB  = 2'b11;

  // Hash mixing constants.
  localparam logic [31:0] MM_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2  = 32'h1b873593;
  localparam logic [31:0] MM_M5  = 32'd5;
  localparam logic [31:0] MM_ADD = 32'he6546b64;
  localparam logic [31:0] MM_LEN = 32'd4;
  localparam logic [31:0] MM_F1  = 32'h85ebca6b;
  localparam logic [31:0] MM_F2  = 32'hc2b2ae35;

  typedef struct packed {
    logic        start;
    logic [31:0] word;
    logic [31:0] seed;
  } hash_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] hash;
  } hash_rsp_t;

endpackage

// ----- rtl/mhse_ram.sv -----
module mhse_ram #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 16320
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/mhse_hash.sv -----
// Iterative 32-bit mixer: one shared multiplier, one multiply per cycle.
module mhse_hash (
  input  logic                clk,
  input  logic                rst,
  input  mhse_pkg::hash_req_t req,
  output mhse_pkg::hash_rsp_t rsp
);

  typedef enum logic [2:0] {HS_IDLE, HS_K2, HS_H1, HS_H2, HS_H3, HS_H4} hs_state_t;

  hs_state_t   state;
  logic [31:0] seed;
  logic [31:0] product;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] pre;
  logic [63:0] full;

  always_comb begin
    pre   = 32'd0;
    mul_a = req.word;
    mul_b = mhse_pkg::MM_C1;
    unique case (state)
      HS_IDLE: begin
        mul_a = req.word;
        mul_b = mhse_pkg::MM_C1;
      end
      HS_K2: begin
        mul_a = {product[16:0], product[31:17]};
        mul_b = mhse_pkg::MM_C2;
      end
      HS_H1: begin
        pre   = seed ^ product;
        mul_a = {pre[18:0], pre[31:19]};
        mul_b = mhse_pkg::MM_M5;
      end
      HS_H2: begin
        pre   = (product + mhse_pkg::MM_ADD) ^ mhse_pkg::MM_LEN;
        mul_a = pre ^ (pre >> 16);
        mul_b = mhse_pkg::MM_F1;
      end
      HS_H3: begin
        mul_a = product ^ (product >> 13);
        mul_b = mhse_pkg::MM_F2;
      end
      HS_H4: begin
        mul_a = product;
        mul_b = mhse_pkg::MM_F2;
      end
      default: begin
        mul_a = req.word;
        mul_b = mhse_pkg::MM_C1;
      end
    endcase
    full = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= HS_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        HS_IDLE: begin
          if (req.start) begin
            seed    <= req.seed;
            product <= full[31:0];
            state   <= HS_K2;
          end
        end
        HS_K2: begin
          product <= full[31:0];
          state   <= HS_H1;
        end
        HS_H1: begin
          product <= full[31:0];
          state   <= HS_H2;
        end
        HS_H2: begin
          product <= full[31:0];
          state   <= HS_H3;
        end
        HS_H3: begin
          product <= full[31:0];
          state   <= HS_H4;
        end
        HS_H4: begin
          rsp.hash <= product ^ (product >> 16);
          rsp.done <= 1'b1;
          state    <= HS_IDLE;
        end
        default: state <= HS_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/multilevel_hash_set_engine_unit.sv -----
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  tuser: req_type; tdata: key
// m_*       out        m_tvalid / m_tready  tdata: success, levels_exhausted
// cfg_*     in         cfg_we               cfg_index, cfg_wdata
//
// Each request hashes its key once per probe (ST_HASH starts the shared multiplier and
// ST_HWAIT waits for its result), then, for each slot it visits while it walks the
// levels, sets the address in ST_LVL and checks the registered read in ST_EVAL. A
// delete that retires a level also steps through ST_MREAD, ST_MEVAL and ST_MNEXT for
// every slot of that level, and hashes and probes every key that it moves up.
// After reset a clearing pass writes every slot, one per cycle (BASE_SIZE times
// 2**MAX_LEVELS - 1 slots, 16320 at the defaults); s_tready stays low meanwhile.
// s_tready is high only while no request is in work; one finished result may wait
// in the output register while the next transaction is taken.
module multilevel_hash_set_engine_unit #(
  parameter int BASE_SIZE  = 64,
  parameter int MAX_LEVELS = 8,
  parameter int MAX_PROBES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] key
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] success, [1] levels_exhausted, [7:2] zero
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int TOTAL = BASE_SIZE * ((1 << MAX_LEVELS) - 1);
  localparam int AW    = $clog2(TOTAL);
  localparam int LW    = $clog2(MAX_LEVELS);
  localparam int LCW   = $clog2(MAX_LEVELS + 1);
  localparam int NPR   = (MAX_PROBES < mhse_pkg::SEED_REGS) ? MAX_PROBES
                                                            : mhse_pkg::SEED_REGS;
  localparam int PW    = (NPR > 1) ? $clog2(NPR) : 1;
  localparam int CW    = (AW + 1 > mhse_pkg::TOMB_W) ? AW + 1 : mhse_pkg::TOMB_W;
  localparam int WW    = mhse_pkg::KEY_W + 2;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HASH, ST_HWAIT, ST_LVL, ST_EVAL, ST_DEL,
    ST_MREAD, ST_MEVAL, ST_MNEXT, ST_RETIRE, ST_FLL, ST_DONE
  } state_t;

  state_t                    state;
  logic [2:0]                probe_count;
  logic [31:0]               seed [mhse_pkg::SEED_REGS];
  logic [AW-1:0]             clr_addr;
  logic [1:0]                op;
  logic                      mig;
  logic [63:0]               cur_key;
  logic [31:0]               bk [NPR];
  logic [PW-1:0]             hp;
  logic [PW-1:0]             pi;
  logic [LCW-1:0]            lvl;
  logic [LCW-1:0]            levels_in_use;
  logic [LW-1:0]             first_live;
  logic [MAX_LEVELS-1:0]     retired;
  logic [mhse_pkg::TOMB_W-1:0] tomb [MAX_LEVELS];
  logic [LW-1:0]             mlv;
  logic [AW-1:0]             ms;
  logic                      ok;
  logic                      exh;

  logic [2:0]                np;
  logic                      last_probe;
  logic                      last_hash;
  logic [LW-1:0]             lvl_ix;
  logic [AW:0]               cur_size;
  logic [AW:0]               mig_size;
  logic [AW-1:0]             slot_addr;
  logic                      insert_mode;
  logic [mhse_pkg::TOMB_W-1:0] tomb_next;

  logic                      ram_we;
  logic [AW-1:0]             ram_addr;
  logic [WW-1:0]             ram_wdata;
  logic [WW-1:0]             ram_rdata;
  logic [1:0]                rd_flags;
  logic [63:0]               rd_key;

  mhse_pkg::hash_req_t       hreq;
  mhse_pkg::hash_rsp_t       hrsp;

  function automatic logic [AW:0] level_size(input logic [LW-1:0] l);
    return (AW + 1)'(BASE_SIZE) << l;
  endfunction

  // Effective probe count: zero acts as one, large values saturate.
  always_comb begin
    if (probe_count == 3'd0) begin
      np = 3'd1;
    end else if (probe_count > 3'(NPR)) begin
      np = 3'(NPR);
    end else begin
      np = probe_count;
    end
  end

  assign last_probe  = (3'(pi) == np - 3'd1);
  assign last_hash   = (3'(hp) == np - 3'd1);
  assign lvl_ix      = lvl[LW-1:0];
  assign cur_size    = level_size(lvl_ix);
  assign mig_size    = level_size(mlv);
  assign insert_mode = mig || (op == mhse_pkg::OP_INSERT);
  assign rd_flags    = ram_rdata[WW-1 -: 2];
  assign rd_key      = ram_rdata[63:0];

  // Slot of the current level and probe: level base plus the masked hash.
  assign slot_addr = (cur_size[AW-1:0] - AW'(BASE_SIZE))
                   + (bk[pi][AW-1:0] & (cur_size[AW-1:0] - AW'(1)));

  assign tomb_next = (tomb[lvl_ix] == mhse_pkg::TOMB_MAX) ? tomb[lvl_ix]
                                                          : tomb[lvl_ix] + 1'b1;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = slot_addr;
    ram_wdata = {mhse_pkg::FLAG_OCC, cur_key};
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
      end
      ST_EVAL: begin
        // Insert into an empty slot or revive a tombstone of the same key.
        ram_we = insert_mode &&
                 (!rd_flags[0] || (rd_key == cur_key && rd_flags[1]));
      end
      ST_DEL: begin
        ram_we    = 1'b1;
        ram_wdata = {mhse_pkg::FLAG_TOMB, cur_key};
      end
      ST_MREAD: ram_addr = (mig_size[AW-1:0] - AW'(BASE_SIZE)) + ms;
      default: ram_we = 1'b0;
    endcase
  end

  mhse_ram #(.WIDTH(WW), .DEPTH(TOTAL)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign hreq.start = (state == ST_HASH);
  assign hreq.word  = cur_key[31:0];
  assign hreq.seed  = seed[2'(hp)];

  mhse_hash u_hash (
    .clk (clk),
    .rst (rst),
    .req (hreq),
    .rsp (hrsp)
  );

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      probe_count   <= 3'd1;
      for (int n = 0; n < mhse_pkg::SEED_REGS; n++) begin
        seed[n] <= 32'(n);
      end
      levels_in_use <= LCW'(1);
      first_live    <= '0;
      retired       <= '0;
      for (int n = 0; n < MAX_LEVELS; n++) begin
        tomb[n] <= '0;
      end
      m_tvalid      <= 1'b0;
      mig           <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mhse_pkg::REG_PROBE_COUNT: probe_count <= cfg_wdata[2:0];
          mhse_pkg::REG_SEED_0:      seed[0]     <= cfg_wdata;
          mhse_pkg::REG_SEED_1:      seed[1]     <= cfg_wdata;
          mhse_pkg::REG_SEED_2:      seed[2]     <= cfg_wdata;
          mhse_pkg::REG_SEED_3:      seed[3]     <= cfg_wdata;
          default: ;
        endcase
      end

      // A taken result empties the output register unless a new one loads it now.
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(TOTAL - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            op      <= s_tuser;
            cur_key <= s_tdata;
            mig     <= 1'b0;
            ok      <= 1'b0;
            exh     <= 1'b0;
            hp      <= '0;
            state   <= ST_HASH;
          end
        end
        ST_HASH: state <= ST_HWAIT;
        ST_HWAIT: begin
          if (hrsp.done) begin
            bk[hp] <= hrsp.hash;
            if (last_hash) begin
              pi <= '0;
              if (mig) begin
                lvl   <= LCW'(mlv) + 1'b1;
                state <= ST_LVL;
              end else if (op == mhse_pkg::OP_QUERY || op == mhse_pkg::OP_INSERT ||
                           op == mhse_pkg::OP_DELETE) begin
                lvl   <= LCW'(first_live);
                state <= ST_LVL;
              end else begin
                state <= ST_DONE;
              end
            end else begin
              hp    <= hp + 1'b1;
              state <= ST_HASH;
            end
          end
        end
        ST_LVL: begin
          if (lvl >= levels_in_use) begin
            if (!insert_mode) begin
              state <= ST_DONE;
            end else if (levels_in_use >= LCW'(MAX_LEVELS)) begin
              exh   <= 1'b1;
              state <= mig ? ST_MNEXT : ST_DONE;
            end else begin
              // Open a new level above the top; it is still clear from reset.
              levels_in_use <= levels_in_use + 1'b1;
            end
          end else if (retired[lvl_ix]) begin
            lvl <= lvl + 1'b1;
            pi  <= '0;
          end else begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (!rd_flags[0] || rd_key == cur_key) begin
            if (insert_mode) begin
              if (!mig) begin
                ok <= !rd_flags[0] || rd_flags[1];
              end
              state <= mig ? ST_MNEXT : ST_DONE;
            end else if (rd_flags[0] && !rd_flags[1]) begin
              if (op == mhse_pkg::OP_DELETE) begin
                state <= ST_DEL;
              end else begin
                ok    <= 1'b1;
                state <= ST_DONE;
              end
            end else begin
              state <= ST_DONE;
            end
          end else begin
            if (last_probe) begin
              pi  <= '0;
              lvl <= lvl + 1'b1;
            end else begin
              pi <= pi + 1'b1;
            end
            state <= ST_LVL;
          end
        end
        ST_DEL: begin
          ok           <= 1'b1;
          tomb[lvl_ix] <= tomb_next;
          if (CW'(tomb_next) > CW'(cur_size >> 2) && (lvl + 1'b1) != levels_in_use) begin
            mlv   <= lvl_ix;
            ms    <= '0;
            state <= ST_MREAD;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_MREAD: state <= ST_MEVAL;
        ST_MEVAL: begin
          if (rd_flags == mhse_pkg::FLAG_OCC) begin
            cur_key <= rd_key;
            mig     <= 1'b1;
            hp      <= '0;
            state   <= ST_HASH;
          end else begin
            state <= ST_MNEXT;
          end
        end
        ST_MNEXT: begin
          if (ms == mig_size[AW-1:0] - AW'(1)) begin
            state <= ST_RETIRE;
          end else begin
            ms    <= ms + 1'b1;
            state <= ST_MREAD;
          end
        end
        ST_RETIRE: begin
          retired[mlv] <= 1'b1;
          state        <= ST_FLL;
        end
        ST_FLL: begin
          // Step the first live level past retired ones, one level a cycle.
          if ((LCW'(first_live) + 1'b1) < levels_in_use && retired[first_live]) begin
            first_live <= first_live + 1'b1;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, exh, ok};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/mhse_checker.sv -----
module mhse_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A waiting result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // One request at a time: a taken transaction makes the block busy.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a transaction");

  // A new result comes when the request ends, so input is ready again.
  a_rise_ready: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result appeared while still busy");

  // Padding bits of a result are zero.
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:2] == 6'd0)
    else $error("result padding not zero");

endmodule

bind multilevel_hash_set_engine_unit mhse_checker u_mhse_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/sv/multilevel_hash_set_engine_unit_tb.sv -----
// Testbench for the multilevel hash set engine.
// A behavioral copy of the set runs beside the block. Every transaction taken on
// the s_* side is applied to it, and the expected result is queued. A checker
// compares each m_* transaction with the oldest queued result, field by field.
// The run goes through directed tests, several register settings and random
// traffic under several idling mixes. One stretch holds the receiver off so that
// the block fills up and stalls its input.
module multilevel_hash_set_engine_unit_tb;

  localparam int BASE = 64;
  localparam int LEVELS = 8;
  localparam int PROBES = 4;
  localparam int SLOTS = BASE * ((1 << LEVELS) - 1);
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic ok;
    logic exh;
  } set_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  multilevel_hash_set_engine_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the register file and the set contents.
  logic [2:0]  sh_probe_count;
  logic [31:0] sh_seed [mhse_pkg::SEED_REGS];
  logic [63:0] sh_key [SLOTS];
  logic [1:0]  sh_flag [SLOTS];
  int unsigned sh_tomb [LEVELS];
  bit          sh_retired [LEVELS];
  int unsigned sh_levels;
  int unsigned sh_first;

  set_result_t pending_results[$];

  // Idling controls, changed per phase by the tests.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned recv_hold = 0;

  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned hits_seen = 0;
  int unsigned exhausted_seen = 0;
  longint      cycles = 0;

  function automatic logic [31:0] rotl(logic [31:0] x, int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  // Murmur3 of one 32-bit word, four bytes long.
  function automatic logic [31:0] murmur_word(logic [31:0] k, logic [31:0] seed);
    logic [31:0] h;
    h = seed;
    k = k * mhse_pkg::MM_C1;
    k = rotl(k, 15);
    k = k * mhse_pkg::MM_C2;
    h ^= k;
    h = rotl(h, 13);
    h = h * mhse_pkg::MM_M5 + mhse_pkg::MM_ADD;
    h ^= mhse_pkg::MM_LEN;
    h ^= h >> 16;
    h = h * mhse_pkg::MM_F1;
    h ^= h >> 13;
    h = h * mhse_pkg::MM_F2;
    h ^= h >> 16;
    return h;
  endfunction

  function automatic int unsigned active_probes();
    int unsigned n;
    n = sh_probe_count;
    if (n < 1) n = 1;
    if (n > PROBES) n = PROBES;
    if (n > mhse_pkg::SEED_REGS) n = mhse_pkg::SEED_REGS;
    return n;
  endfunction

  function automatic int unsigned lvl_base(int unsigned lv);
    return BASE * ((1 << lv) - 1);
  endfunction

  // Places a key from level 'from' upward, opening levels as needed.
  function automatic bit place_key(logic [63:0] key, int unsigned from, int unsigned np,
                                   ref bit exh);
    int unsigned idx;
    logic [31:0] h;
    forever begin
      for (int unsigned j = from; j < sh_levels; j++) begin
        if (!sh_retired[j]) begin
          for (int unsigned i = 0; i < np; i++) begin
            h = murmur_word(key[31:0], sh_seed[i]);
            idx = lvl_base(j) + (h & ((BASE << j) - 1));
            if (!sh_flag[idx][0]) begin
              sh_key[idx] = key;
              sh_flag[idx] = mhse_pkg::FLAG_OCC;
              return 1'b1;
            end
            if (sh_key[idx] == key) begin
              if (sh_flag[idx][1]) begin
                sh_flag[idx] = mhse_pkg::FLAG_OCC;
                return 1'b1;
              end
              return 1'b0;
            end
          end
        end
      end
      if (sh_levels >= LEVELS) begin
        exh = 1'b1;
        return 1'b0;
      end
      for (int unsigned s = 0; s < (BASE << sh_levels); s++)
        sh_flag[lvl_base(sh_levels) + s] = mhse_pkg::FLAG_EMPTY;
      sh_tomb[sh_levels] = 0;
      sh_retired[sh_levels] = 1'b0;
      from = sh_levels;
      sh_levels++;
    end
  endfunction

  // Returns the slot of a live key, or -1; the level lands in lvl.
  function automatic int lookup_key(logic [63:0] key, int unsigned np,
                                    ref int unsigned lvl);
    int unsigned idx;
    logic [31:0] h;
    for (int unsigned j = sh_first; j < sh_levels; j++) begin
      if (!sh_retired[j]) begin
        for (int unsigned i = 0; i < np; i++) begin
          h = murmur_word(key[31:0], sh_seed[i]);
          idx = lvl_base(j) + (h & ((BASE << j) - 1));
          if (!sh_flag[idx][0]) return -1;
          if (sh_key[idx] == key) begin
            if (sh_flag[idx][1]) return -1;
            lvl = j;
            return int'(idx);
          end
        end
      end
    end
    return -1;
  endfunction

  // Moves the live keys of a level upward and retires the level.
  function automatic void retire_level(int unsigned lv, int unsigned np, ref bit exh);
    int unsigned idx;
    bit dummy;
    for (int unsigned s = 0; s < (BASE << lv); s++) begin
      idx = lvl_base(lv) + s;
      if (sh_flag[idx] == mhse_pkg::FLAG_OCC)
        dummy = place_key(sh_key[idx], lv + 1, np, exh);
    end
    sh_retired[lv] = 1'b1;
    while (sh_first + 1 < sh_levels && sh_retired[sh_first]) sh_first++;
  endfunction

  function automatic set_result_t apply_request(logic [1:0] op, logic [63:0] key);
    set_result_t r;
    int unsigned np, lvl;
    int idx;
    bit exh;
    np = active_probes();
    exh = 1'b0;
    lvl = 0;
    r = '0;
    case (op)
      mhse_pkg::OP_QUERY: r.ok = lookup_key(key, np, lvl) >= 0;
      mhse_pkg::OP_INSERT: r.ok = place_key(key, sh_first, np, exh);
      mhse_pkg::OP_DELETE: begin
        idx = lookup_key(key, np, lvl);
        if (idx >= 0) begin
          sh_flag[idx] = mhse_pkg::FLAG_TOMB;
          r.ok = 1'b1;
          if (sh_tomb[lvl] < mhse_pkg::TOMB_MAX) sh_tomb[lvl]++;
          if (sh_tomb[lvl] > ((BASE << lvl) >> 2) && lvl + 1 != sh_levels)
            retire_level(lvl, np, exh);
        end
      end
      default: ;
    endcase
    r.exh = exh;
    return r;
  endfunction

  // Offers one request, maybe after an idle gap, and predicts it once taken.
  // Called and returning at a falling edge.
  task automatic send_request(logic [1:0] op, logic [63:0] key);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= key;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_request(op, key));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic stop_sending();
    s_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  // Waits for every result, then lets the block settle; called at a falling edge.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] index, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (index)
      mhse_pkg::REG_PROBE_COUNT: sh_probe_count = value[2:0];
      mhse_pkg::REG_SEED_0: sh_seed[0] = value;
      mhse_pkg::REG_SEED_1: sh_seed[1] = value;
      mhse_pkg::REG_SEED_2: sh_seed[2] = value;
      mhse_pkg::REG_SEED_3: sh_seed[3] = value;
      default: ;
    endcase
  endtask

  // Receiver: stalls at random, or for a counted hold-off when one is asked.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (recv_hold != 0) begin
      m_tready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Checker: each result transaction against the oldest expectation.
  always @(posedge clk) begin
    set_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tdata[0]) hits_seen++;
      if (m_tdata[1]) exhausted_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual success=%0b exhausted=%0b",
                 $time, m_tdata[0], m_tdata[1]);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[0] !== want.ok) begin
          $display("%0t: success mismatch, expected %0b, actual %0b",
                   $time, want.ok, m_tdata[0]);
          errors++;
        end
        if (m_tdata[1] !== want.exh) begin
          $display("%0t: levels_exhausted mismatch, expected %0b, actual %0b",
                   $time, want.exh, m_tdata[1]);
          errors++;
        end
      end
    end
  end

  // Watchdog over the whole run, the clearing pass after reset included.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Keys with a shared low word hash alike, so they collide on every level.
  function automatic logic [63:0] pool_key();
    logic [63:0] k;
    k[31:0] = 32'h1000 + $urandom_range(23) * 32'h0101_0101;
    k[63:32] = $urandom_range(11);
    if ($urandom_range(9) == 0) k = {$urandom, $urandom};
    return k;
  endfunction

  task automatic test_basic_ops();
    send_request(mhse_pkg::OP_QUERY, 64'd0);
    send_request(mhse_pkg::OP_INSERT, 64'd0);
    send_request(mhse_pkg::OP_INSERT, 64'd0);              // duplicate of a live key
    send_request(mhse_pkg::OP_QUERY, 64'd0);
    send_request(mhse_pkg::OP_INSERT, 64'hffff_ffff_ffff_ffff);
    send_request(mhse_pkg::OP_QUERY, 64'hffff_ffff_ffff_ffff);
    send_request(mhse_pkg::OP_DELETE, 64'd0);
    send_request(mhse_pkg::OP_DELETE, 64'd0);              // key already tombstoned
    send_request(mhse_pkg::OP_QUERY, 64'd0);
    send_request(mhse_pkg::OP_INSERT, 64'd0);              // tombstone revived
    send_request(2'd3, 64'hffff_ffff_ffff_ffff);           // unknown request code
    send_request(mhse_pkg::OP_QUERY, 64'hffff_ffff_ffff_ffff);
    drain();
  endtask

  // Nine keys with one low word but different high words need nine levels.
  task automatic test_level_exhaustion();
    for (int i = 1; i <= 9; i++)
      send_request(mhse_pkg::OP_INSERT, {32'(i), 32'hdead_beef});
    send_request(mhse_pkg::OP_QUERY, {32'd9, 32'hdead_beef});
    send_request(mhse_pkg::OP_QUERY, {32'd8, 32'hdead_beef});
    drain();
  endtask

  // Enough deletes on a lower level to push it past a quarter of tombstones.
  task automatic test_level_retire();
    for (int i = 0; i < 24; i++)
      send_request(mhse_pkg::OP_INSERT, 64'h5_0000 + i * 64'h3b9);
    for (int i = 0; i < 24; i++)
      send_request(mhse_pkg::OP_DELETE, 64'h5_0000 + i * 64'h3b9);
    send_request(mhse_pkg::OP_QUERY, {32'd3, 32'hdead_beef});
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(mhse_pkg::REG_PROBE_COUNT, 32'd0);           // acts as one probe
    write_reg(mhse_pkg::REG_SEED_0, 32'hffff_ffff);
    send_request(mhse_pkg::OP_INSERT, 64'h77);
    send_request(mhse_pkg::OP_QUERY, 64'h77);
    drain();
    write_reg(mhse_pkg::REG_PROBE_COUNT, 32'd7);           // saturates at four
    write_reg(mhse_pkg::REG_SEED_1, 32'h0);
    write_reg(mhse_pkg::REG_SEED_2, 32'hffff_ffff);
    write_reg(mhse_pkg::REG_SEED_3, 32'h8000_0001);
    send_request(mhse_pkg::OP_INSERT, 64'h78);
    send_request(mhse_pkg::OP_QUERY, 64'h77);
    send_request(mhse_pkg::OP_DELETE, 64'h78);
    drain();
  endtask

  task automatic run_random(int n);
    int unsigned r;
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      op = r < 45 ? mhse_pkg::OP_INSERT : r < 70 ? mhse_pkg::OP_QUERY :
           r < 97 ? mhse_pkg::OP_DELETE : 2'd3;
      send_request(op, pool_key());
    end
    drain();
  endtask

  task automatic test_random_phases();
    logic [2:0] counts [4] = '{3'd1, 3'd2, 3'd4, 3'd3};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(mhse_pkg::REG_PROBE_COUNT, 32'(counts[ph]));
      write_reg(mhse_pkg::REG_SEED_0 + 3'(ph), $urandom);
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 73 : 27) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 73 : 27) : 0;
      run_random(110);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // The receiver holds off while requests keep coming, so input stalls.
  task automatic test_output_backpressure();
    recv_hold = 400;
    for (int i = 0; i < 10; i++) send_request(mhse_pkg::OP_INSERT, pool_key());
    run_random(10);
  endtask

  initial begin
    sh_probe_count = 3'd1;
    for (int i = 0; i < mhse_pkg::SEED_REGS; i++) sh_seed[i] = 32'(i);
    for (int i = 0; i < SLOTS; i++) begin
      sh_key[i] = '0;
      sh_flag[i] = mhse_pkg::FLAG_EMPTY;
    end
    for (int i = 0; i < LEVELS; i++) begin
      sh_tomb[i] = 0;
      sh_retired[i] = 1'b0;
    end
    sh_levels = 1;
    sh_first = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_basic_ops();
    test_level_exhaustion();
    test_level_retire();
    test_register_extremes();
    test_output_backpressure();
    test_random_phases();
    stop_sending();
    drain();
    $display("Ran %0d requests over several probe counts, seeds and idling mixes.", items_sent);
    $display("Checked %0d results: %0d successes, %0d with levels exhausted.",
             results_seen, hits_seen, exhausted_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
